@@ rtl/core/d2f72_pkg.sv @@
// ----------------------------------------------------------------------------
// d2f72_pkg: shared types and constants
// Field widths and pipeline payload types for the binary64 to float72 block.
// ----------------------------------------------------------------------------
package d2f72_pkg;

  localparam int unsigned IN_W     = 64;
  localparam int unsigned EXP_W    = 8;
  localparam int unsigned MANT_W   = 64;
  localparam int unsigned FRAC_W   = 52;
  localparam int unsigned BEXP_W   = 11;
  localparam int unsigned LZC_W    = 6;
  localparam int unsigned EXW      = 12;

  localparam logic [BEXP_W-1:0] BEXP_MAX      = 11'h7FF;
  localparam logic [EXP_W-1:0]  ZERO_EXPONENT = 8'h80;

  // stage 1 -> stage 2: decoded fields plus leading-zero count
  typedef struct packed {
    logic              neg;
    logic              special;
    logic              zero;
    logic [MANT_W-1:0] mag;
    logic [LZC_W-1:0]  shift;
    logic [EXW-1:0]    ex;
  } dec_t;

  // stage 2 -> stage 3: aligned magnitude
  typedef struct packed {
    logic              neg;
    logic              special;
    logic              zero;
    logic [MANT_W-1:0] mag;
    logic [EXW-1:0]    ex;
  } aln_t;

  typedef struct packed {
    logic [EXP_W-1:0]  exponent;
    logic [MANT_W-1:0] mantissa;
    logic              special;
  } res_t;

endpackage

@@ rtl/core/d2f72_stream_if.sv @@
// ----------------------------------------------------------------------------
// d2f72_stream_if: valid/ready channel
// Carries one request payload of parameterized width.
// ----------------------------------------------------------------------------
interface d2f72_stream_if #(
  parameter int unsigned W = 64
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/d2f72_stage.sv @@
// ----------------------------------------------------------------------------
// d2f72_stage: pipeline register slice
// Holds one request and its valid bit; advances when downstream has room.
// ----------------------------------------------------------------------------
module d2f72_stage #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end
endmodule

@@ rtl/core/d2f72_decode.sv @@
// ----------------------------------------------------------------------------
// d2f72_decode: field split and leading-zero count
// Classifies the input and finds the left shift that puts the top one at 62.
// ----------------------------------------------------------------------------
module d2f72_decode (
  input  logic [d2f72_pkg::IN_W-1:0] bits,
  output d2f72_pkg::dec_t            dec
);
  logic [d2f72_pkg::BEXP_W-1:0] bexp;
  logic [d2f72_pkg::FRAC_W-1:0] frac;
  logic [d2f72_pkg::LZC_W-1:0]  msb;

  assign bexp = bits[62:52];
  assign frac = bits[51:0];

  // priority search for the top set bit of a subnormal fraction
  always_comb begin
    msb = '0;
    for (int i = 0; i < d2f72_pkg::FRAC_W; i++) begin
      if (frac[i]) msb = d2f72_pkg::LZC_W'(i);
    end
  end

  always_comb begin
    dec.neg     = bits[63];
    dec.special = (bexp == d2f72_pkg::BEXP_MAX);
    dec.zero    = (bexp == '0) && (frac == '0);
    if (bexp != '0) begin
      dec.mag   = {11'd0, 1'b1, frac};
      dec.shift = 6'd10;
      dec.ex    = {1'b0, bexp} - 12'd1022;
    end else begin
      dec.mag   = {12'd0, frac};
      dec.shift = 6'd62 - msb;
      dec.ex    = {6'd0, msb} - 12'd1073;
    end
  end
endmodule

@@ rtl/core/ieee_double_to_float72.sv @@
// ----------------------------------------------------------------------------
// ieee_double_to_float72: binary64 to 72-bit float converter
// Three-stage pipeline: decode/count, align, negate/pack.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (sink)   carries ieee_bits, one raw binary64 pattern per request.
//   out_ch (source) carries {exponent, mantissa, special}.
//   A request is moved when valid and ready are both high.
// Registers: three register stages; the accepting edge loads the first one,
//   and the result shows on out_ch once it reaches the third, u_s3.
// Throughput: one request per cycle while out_ch.ready holds high; the
//   stages are decode with the leading-zero count, the barrel shift, and
//   the negate with pack. The widest logic per stage is the 52-bit priority
//   search, the 64-bit shift or the 64-bit negate.
// Reset: rst clears the valid bits of all stages; nothing is in flight after.
// Stall: when the receiver holds ready low, full stages hold their request
//   and ready back-propagates stage by stage, so no request is lost or
//   repeated; bubbles are squeezed out while stalled.
// Specials: infinity or NaN give zero fields with special set; either zero
//   gives exponent 0x80.
// ----------------------------------------------------------------------------
module ieee_double_to_float72 (
  input  logic                clk,
  input  logic                rst,
  d2f72_stream_if.sink        in_ch,
  d2f72_stream_if.source      out_ch
);
  localparam int unsigned DW = $bits(d2f72_pkg::dec_t);
  localparam int unsigned AW = $bits(d2f72_pkg::aln_t);
  localparam int unsigned RW = $bits(d2f72_pkg::res_t);

  d2f72_pkg::dec_t dec_next, dec;
  d2f72_pkg::aln_t aln_next, aln;
  d2f72_pkg::res_t res_next, res;
  logic s1_valid, s1_ready, s2_valid, s2_ready;

  // stage 1: decode
  d2f72_decode u_decode (.bits(in_ch.data), .dec(dec_next));

  d2f72_stage #(.W(DW)) u_s1 (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(dec_next),
    .out_valid(s1_valid), .out_ready(s1_ready), .out_data(dec)
  );

  // stage 2: align the leading one to bit 62
  always_comb begin
    aln_next.neg     = dec.neg;
    aln_next.special = dec.special;
    aln_next.zero    = dec.zero;
    aln_next.mag     = dec.mag << dec.shift;
    aln_next.ex      = dec.ex;
  end

  d2f72_stage #(.W(AW)) u_s2 (
    .clk, .rst,
    .in_valid(s1_valid), .in_ready(s1_ready), .in_data(aln_next),
    .out_valid(s2_valid), .out_ready(s2_ready), .out_data(aln)
  );

  // stage 3: sign, special cases, pack
  always_comb begin
    res_next.special  = 1'b0;
    res_next.exponent = aln.ex[7:0];
    res_next.mantissa = aln.mag;
    if (aln.special) begin
      res_next.special  = 1'b1;
      res_next.exponent = '0;
      res_next.mantissa = '0;
    end else if (aln.zero) begin
      res_next.exponent = d2f72_pkg::ZERO_EXPONENT;
      res_next.mantissa = '0;
    end else if (aln.neg) begin
      if (aln.mag == 64'h4000_0000_0000_0000) begin
        res_next.mantissa = 64'h8000_0000_0000_0000;
        res_next.exponent = aln.ex[7:0] - 8'd1;
      end else begin
        res_next.mantissa = 64'd0 - aln.mag;
      end
    end
  end

  d2f72_stage #(.W(RW)) u_s3 (
    .clk, .rst,
    .in_valid(s2_valid), .in_ready(s2_ready), .in_data(res_next),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(res)
  );

  assign out_ch.data = res;

  // aligned magnitude of a finite nonzero value has its top one at bit 62
  a_align: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !aln.special && !aln.zero |-> aln.mag[63:62] == 2'b01)
    else $error("alignment lost the leading one");

  // a special result carries zero fields
  a_special: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && res.special |-> res.exponent == '0 && res.mantissa == '0)
    else $error("special result not cleared");

  // a stalled output stage holds its request
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res))
    else $error("output changed under stall");

  // upstream ready follows downstream room
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ch.ready)
    else $error("input stalled with empty first stage");
endmodule
